[src/assert_macros.svh]
// assertion macros shared by the checker files
// expects signals named clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SLI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define SLI_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[src/sli_pkg.sv]
// shared types and constants of the sorted list block
// no dependencies
`default_nettype none

package sli_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_DUMP   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ENTRY     = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_DEL_RD,
		S_DEL_CMP,
		S_DMP_RD,
		S_DMP_OUT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_t;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] item;
		logic             last;
	} res_t;

endpackage

`default_nettype wire

[src/sli_cmp.sv]
// shared signed comparator: operand against a stored entry
// depends on sli_pkg
`default_nettype none

module sli_cmp (
	input  wire logic [sli_pkg::VAL_W-1:0] a,
	input  wire logic [sli_pkg::VAL_W-1:0] b,
	output sli_pkg::cmp_t                  res
);

	assign res.gt = $signed(a) > $signed(b);
	assign res.eq = (a == b);

endmodule

`default_nettype wire

[src/sli_table.sv]
// entry store: one write port, one read port with registered data
// depends on sli_pkg
`default_nettype none

module sli_table #(
	parameter int DEPTH = sli_pkg::DEF_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [sli_pkg::VAL_W-1:0]   wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [sli_pkg::VAL_W-1:0]   rdata
);

	logic [sli_pkg::VAL_W-1:0] mem [DEPTH];
	logic [sli_pkg::VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/sli_seq.sv]
// sequencer: walks the table one entry per read, shifting entries with the
// shared comparator; depends on sli_pkg and sli_cmp
`default_nettype none

module sli_seq #(
	parameter int CAPACITY = sli_pkg::DEF_CAPACITY,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                in_op,
	input  wire logic [sli_pkg::VAL_W-1:0] in_value,
	output logic                           we,
	output logic      [AW-1:0]             waddr,
	output logic      [sli_pkg::VAL_W-1:0] wdata,
	output logic                           re,
	output logic      [AW-1:0]             raddr,
	input  wire logic [sli_pkg::VAL_W-1:0] rdata,
	output logic                           res_valid,
	output sli_pkg::res_t                  res,
	input  wire logic                      res_take
);

	sli_pkg::state_t  state_q, state_d;
	sli_pkg::status_t status_q, status_d;
	logic [sli_pkg::VAL_W-1:0] value_q, value_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] count_q, count_d;
	logic          found_q, found_d;
	logic          last_pos;
	sli_pkg::cmp_t cmp;

	sli_cmp u_cmp (
		.a   (value_q),
		.b   (rdata),
		.res (cmp)
	);

	assign last_pos = (CW'(idx_q) == count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sli_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		value_q  <= value_d;
		idx_q    <= idx_d;
		found_q  <= found_d;
	end

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		value_d    = value_q;
		idx_d      = idx_q;
		count_d    = count_q;
		found_d    = found_q;
		in_ready   = 1'b0;
		we         = 1'b0;
		waddr      = idx_q + AW'(1);
		wdata      = rdata;
		re         = 1'b0;
		raddr      = idx_q;
		res_valid  = 1'b0;
		res.status = status_q;
		res.item   = '0;
		res.last   = 1'b1;
		case (state_q)
			sli_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					value_d = in_value;
					found_d = 1'b0;
					idx_d   = '0;
					case (in_op)
						sli_pkg::OP_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								status_d = sli_pkg::ST_FULL;
								state_d  = sli_pkg::S_RESP;
							end else if (count_q == '0) begin
								we       = 1'b1;
								waddr    = '0;
								wdata    = in_value;
								count_d  = count_q + CW'(1);
								status_d = sli_pkg::ST_INSERTED;
								state_d  = sli_pkg::S_RESP;
							end else begin
								// walk down from the top entry
								idx_d   = AW'(count_q - CW'(1));
								state_d = sli_pkg::S_INS_RD;
							end
						end
						sli_pkg::OP_DELETE: begin
							if (count_q == '0) begin
								status_d = sli_pkg::ST_NOT_FOUND;
								state_d  = sli_pkg::S_RESP;
							end else begin
								state_d = sli_pkg::S_DEL_RD;
							end
						end
						sli_pkg::OP_DUMP: begin
							if (count_q == '0) begin
								status_d = sli_pkg::ST_EMPTY;
								state_d  = sli_pkg::S_RESP;
							end else begin
								state_d = sli_pkg::S_DMP_RD;
							end
						end
						default: begin
							state_d = sli_pkg::S_IDLE;
						end
					endcase
				end
			end
			sli_pkg::S_INS_RD: begin
				re      = 1'b1;
				state_d = sli_pkg::S_INS_CMP;
			end
			sli_pkg::S_INS_CMP: begin
				we = 1'b1;
				if (cmp.gt) begin
					// slot found just above this entry
					wdata    = value_q;
					count_d  = count_q + CW'(1);
					status_d = sli_pkg::ST_INSERTED;
					state_d  = sli_pkg::S_RESP;
				end else if (idx_q == '0) begin
					state_d = sli_pkg::S_INS_PUT;
				end else begin
					idx_d   = idx_q - AW'(1);
					state_d = sli_pkg::S_INS_RD;
				end
			end
			sli_pkg::S_INS_PUT: begin
				we       = 1'b1;
				waddr    = '0;
				wdata    = value_q;
				count_d  = count_q + CW'(1);
				status_d = sli_pkg::ST_INSERTED;
				state_d  = sli_pkg::S_RESP;
			end
			sli_pkg::S_DEL_RD: begin
				re      = 1'b1;
				state_d = sli_pkg::S_DEL_CMP;
			end
			sli_pkg::S_DEL_CMP: begin
				// once the match is passed, every later entry moves down one
				if (found_q) begin
					we    = 1'b1;
					waddr = idx_q - AW'(1);
				end else if (cmp.eq) begin
					found_d = 1'b1;
				end
				if (last_pos) begin
					if (found_q || cmp.eq) begin
						count_d  = count_q - CW'(1);
						status_d = sli_pkg::ST_DELETED;
					end else begin
						status_d = sli_pkg::ST_NOT_FOUND;
					end
					state_d = sli_pkg::S_RESP;
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = sli_pkg::S_DEL_RD;
				end
			end
			sli_pkg::S_DMP_RD: begin
				re      = 1'b1;
				state_d = sli_pkg::S_DMP_OUT;
			end
			sli_pkg::S_DMP_OUT: begin
				res_valid  = 1'b1;
				res.status = sli_pkg::ST_ENTRY;
				res.item   = rdata;
				res.last   = last_pos;
				if (res_take) begin
					if (last_pos) begin
						state_d = sli_pkg::S_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = sli_pkg::S_DMP_RD;
					end
				end
			end
			sli_pkg::S_RESP: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = sli_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sli_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/sorted_list_insert_delete.sv]
// Sorted table of signed 32-bit values, ascending, up to CAPACITY entries.
// Input channel s_axis: tuser carries the operation (insert, delete, dump),
// tdata the value. Output channel m_axis: tuser carries the status, tdata
// the entry during a dump (zero otherwise), tlast marks the final result of
// an operation. Insert and delete give one result, dump one per entry or a
// single empty result; operation code 3 is taken and gives nothing.
// One item at a time: s_axis_tready is high only while the sequencer idles.
// Each table step of an insert or delete is a read of the entry store followed
// by a compare in the shared comparator; a dump step reads an entry and hands
// it out. Full, empty or not-found cases with nothing to walk give their result
// straight from idle, without reading the entry store.
// A result lands in an output register, so the next item is taken while it
// still waits. A stalled receiver holds the output and, during a dump, the
// walk. Reset empties the table (fill count to zero); the stored words are
// not cleared and never read before being written.
// depends on sli_pkg, sli_seq, sli_table, sli_cmp
`default_nettype none

module sorted_list_insert_delete #(
	parameter int CAPACITY = sli_pkg::DEF_CAPACITY
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // value
	input  wire logic [1:0]  s_axis_tuser,  // operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // item
	output logic      [2:0]  m_axis_tuser,  // status
	output logic             m_axis_tlast
);

	localparam int AW = $clog2(CAPACITY);

	logic                      we, re;
	logic [AW-1:0]             waddr, raddr;
	logic [sli_pkg::VAL_W-1:0] wdata, rdata;
	logic                      res_valid, res_take;
	sli_pkg::res_t             res;
	logic                      out_valid_q;
	sli_pkg::res_t             out_res_q;

	sli_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_value  (s_axis_tdata),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	sli_table #(
		.DEPTH (CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// output register frees as it is taken
	assign res_take = res_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_res_q.item;
	assign m_axis_tuser  = out_res_q.status;
	assign m_axis_tlast  = out_res_q.last;

endmodule

`default_nettype wire

[src/sli_chk.sv]
// port checker for the sorted list block, bound to the top level
// depends on sli_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module sli_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [2:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	logic        out_stall;
	logic        not_entry;
	logic [35:0] out_word;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign not_entry = m_axis_tvalid && (m_axis_tuser != sli_pkg::ST_ENTRY);
	assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

	// a stalled result keeps its payload
	`SLI_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled result changed")

	// only dump entries carry data
	`SLI_ASSERT(a_item_zero, not_entry |-> (m_axis_tdata == '0), "non-entry result with data")

	// every status but entry ends its operation
	`SLI_ASSERT(a_single_last, not_entry |-> m_axis_tlast, "single result without last")

	`SLI_NEVER(a_status_code, m_axis_tvalid && (m_axis_tuser > sli_pkg::ST_EMPTY), "unknown status")

endmodule

bind sorted_list_insert_delete sli_chk u_chk (.*);

`default_nettype wire
